@@ hw/rtl/stisd_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted table package
// Shared sizes, operation codes, status codes and cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package stisd_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Load selects for one cell; at most one is set in a cycle.
    typedef struct packed {
        logic load_prev;
        logic load_new;
        logic load_next;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/stisd_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one entry, compares it against the operand and loads from the left
// neighbor, the operand or the right neighbor as the control selects.
// ----------------------------------------------------------------------------
`default_nettype none

module stisd_cell
    import stisd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              occupied,
    input  wire logic [DATA_W-1:0] new_value,
    input  wire logic [DATA_W-1:0] prev_value,
    input  wire logic [DATA_W-1:0] next_value,
    input  wire cell_ctl_t         ctl,
    output logic      [DATA_W-1:0] entry,
    output logic                   greater,
    output logic                   match
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    assign entry   = entry_reg;
    assign greater = occupied && ($signed(entry_reg) > $signed(new_value));
    assign match   = occupied && (entry_reg == new_value);

    always_comb begin
        entry_next = entry_reg;
        if (ctl.load_prev) begin
            entry_next = prev_value;
        end else if (ctl.load_new) begin
            entry_next = new_value;
        end else if (ctl.load_next) begin
            entry_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_table_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// Sorted table with insert, delete and search
// Row of compare-and-shift cells holding up to CAPACITY signed values in
// ascending order, with a registered result channel.
// ----------------------------------------------------------------------------
// Every cell compares its entry with the operand in parallel and the row
// shifts right (insert) or left (delete) at the clock edge that accepts the
// transaction, so a new transaction can be accepted every cycle while the
// output is not stalled. The result sits in an output register; the input
// is ready whenever that register is empty or is being taken in the same
// cycle. There is no clearing pass after reset; the table starts empty.
`default_nettype none

module sorted_table_insert_delete_search
    import stisd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_result_value,
    output logic [4:0]       m_entry_count
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [1:0]       m_status_reg;
    logic [1:0]       m_status_next;
    logic [31:0]      m_result_value_reg;
    logic [31:0]      m_result_value_next;
    logic [4:0]       m_entry_count_reg;
    logic [4:0]       m_entry_count_next;

    logic [CAPACITY-1:0] occupied;
    logic [CAPACITY-1:0] greater;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] ins_at;
    logic [CAPACITY-1:0] del_from;
    logic [DATA_W-1:0]   entries [CAPACITY];
    cell_ctl_t           ctl [CAPACITY];

    logic accept;
    logic is_full;
    logic is_empty;
    logic found;
    logic do_insert;
    logic do_delete;

    assign accept   = s_valid && s_ready;
    assign s_ready  = !m_valid_reg || m_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign found    = |match;

    assign do_insert = accept && (s_action == ACT_INSERT) && !is_full;
    assign do_delete = accept && (s_action == ACT_DELETE) && found;

    // A cell is an insert point when it is empty or holds a larger value;
    // since the row is sorted this marks a contiguous upper run.
    assign ins_at = ~occupied | greater;

    // Cells at and above the first match pull from the right on delete.
    assign del_from = ~((match & (~match + CAPACITY'(1))) - CAPACITY'(1));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_W-1:0] prev_value;
            logic [DATA_W-1:0] next_value;
            logic              prev_ins;

            assign occupied[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0) begin : g_first
                assign prev_value = s_value;
                assign prev_ins   = 1'b0;
            end else begin : g_mid
                assign prev_value = entries[gi-1];
                assign prev_ins   = ins_at[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign next_value = s_value;
                assign ctl[gi].load_next = 1'b0;
            end else begin : g_not_last
                assign next_value = entries[gi+1];
                assign ctl[gi].load_next = do_delete && del_from[gi];
            end

            assign ctl[gi].load_prev = do_insert && prev_ins;
            assign ctl[gi].load_new  = do_insert && ins_at[gi] && !prev_ins;

            stisd_cell u_cell (
                .aclk       (aclk),
                .occupied   (occupied[gi]),
                .new_value  (s_value),
                .prev_value (prev_value),
                .next_value (next_value),
                .ctl        (ctl[gi]),
                .entry      (entries[gi]),
                .greater    (greater[gi]),
                .match      (match[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next          = count_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_status_next       = m_status_reg;
        m_result_value_next = m_result_value_reg;
        m_entry_count_next  = m_entry_count_reg;
        if (accept) begin
            m_valid_next        = 1'b1;
            m_status_next       = ST_MISSING;
            m_result_value_next = '0;
            case (s_action)
                ACT_INSERT: begin
                    if (is_full) begin
                        m_status_next = ST_FULL;
                    end else begin
                        count_next          = count_reg + CNT_W'(1);
                        m_status_next       = ST_DONE;
                        m_result_value_next = s_value;
                    end
                end
                ACT_DELETE: begin
                    if (is_empty) begin
                        m_status_next = ST_EMPTY;
                    end else if (found) begin
                        count_next          = count_reg - CNT_W'(1);
                        m_status_next       = ST_DONE;
                        m_result_value_next = s_value;
                    end
                end
                ACT_SEARCH: begin
                    if (is_empty) begin
                        m_status_next = ST_EMPTY;
                    end else if (found) begin
                        m_status_next       = ST_DONE;
                        m_result_value_next = s_value;
                    end
                end
                default: begin
                    m_status_next = ST_MISSING;
                end
            endcase
            m_entry_count_next = count_next[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_status_reg       <= m_status_next;
        m_result_value_reg <= m_result_value_next;
        m_entry_count_reg  <= m_entry_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_result_value_reg;
    assign m_entry_count  = m_entry_count_reg;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A successful insert grows the table by exactly one entry.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table by one");

    // Any status other than done carries a zero value.
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_DONE)) |-> (m_result_value_reg == '0))
        else $error("nonzero value with a failure status");

    // The reported count matches the table after the transaction.
    a_count_report: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_entry_count_reg == count_reg[4:0]))
        else $error("reported count differs from table count");

endmodule

`default_nettype wire
